// File: rtl/core/ephit_pkg.sv
// ----------------------------------------------------------------------------
// ephit_pkg
// Shared widths, register indexes and arithmetic helpers for the ellipse
// point hit test core.
// ----------------------------------------------------------------------------
package ephit_pkg;

  localparam int CoordW   = 15;
  localparam int InDataW  = 32;   // two coordinates, padded to whole bytes
  localparam int OutDataW = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 15;

  // register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] REG_CORNER_A_X = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CORNER_A_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CORNER_B_X = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CORNER_B_Y = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FILLED     = 3'd4;

  // probe offset of the outline test, doubled because offsets are 2x - sum
  localparam logic signed [17:0] ProbeOff2 = 18'sd4;

  localparam int OffW   = 17;   // |2p - sum| including probe offset
  localparam int SqW    = 33;   // square of an offset
  localparam int SideW  = 15;   // box width or height
  localparam int Side2W = 30;
  localparam int ProdW  = 63;
  localparam int MeasW  = 64;
  localparam int RadW   = 60;

  typedef logic signed [CoordW-1:0] coord_t;

  function automatic logic [SideW-1:0] abs_side(logic signed [15:0] v);
    logic [15:0] m;
    m = v[15] ? 16'(-v) : 16'(v);
    return m[SideW-1:0];
  endfunction

  function automatic logic [OffW-1:0] abs_off(logic signed [17:0] v);
    logic [17:0] m;
    m = v[17] ? 18'(-v) : 18'(v);
    return m[OffW-1:0];
  endfunction

  function automatic logic [SqW-1:0] square_off(logic [OffW-1:0] d);
    logic [2*OffW-1:0] p;
    p = d * d;
    return p[SqW-1:0];
  endfunction

  function automatic logic [ProdW-1:0] scale_sq(logic [SqW-1:0] a,
                                                logic [Side2W-1:0] b);
    logic [ProdW-1:0] p;
    p = a * b;
    return p;
  endfunction

  // strictly between in either direction
  function automatic logic between(logic a_lt, logic r_lt_b, logic a_gt,
                                   logic r_gt_b);
    return (a_lt && r_lt_b) || (a_gt && r_gt_b);
  endfunction

endpackage

// File: rtl/core/ellipse_point_hit_test_core.sv
// ----------------------------------------------------------------------------
// ellipse_point_hit_test_core
// Tests query points against an axis-aligned ellipse inscribed in a box
// set by two configured corners, in filled or outline mode.
// ----------------------------------------------------------------------------
//
//  channel  | direction | fields (low bit up)
//  ---------+-----------+------------------------------------------------
//  in_*     | request   | tdata: point_x[14:0], point_y[29:15], zero pad
//  out_*    | result    | tdata: hit[0], zero pad
//  cfg_*    | write     | index 0..4, data: register value in low bits
//
//  one request per cycle sustained while out_tready stays high; each request
//  passes through the six-stage multiplier and compare pipeline and then the
//  output register before out_tvalid is raised.
//  rst_n (synchronous) clears all stage valids and the corner registers.
//  stalls on out_tready hold the result; upstream stages keep filling empty
//  slots, so in_tready drops only when every stage is occupied.
//  cfg_ready is always high.
//
module ellipse_point_hit_test_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ephit_pkg::InDataW-1:0]   in_tdata,   // point_x, point_y
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ephit_pkg::OutDataW-1:0]  out_tdata,  // hit
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ephit_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ephit_pkg::CfgDataW-1:0]  cfg_data
);
  import ephit_pkg::*;

  localparam int NStg = 7;

  // configuration and values derived from it
  coord_t             ax_r, ay_r, bx_r, by_r;
  logic               filled_r;
  logic [SideW-1:0]   w_r, h_r;
  logic [Side2W-1:0]  w2_r, h2_r;
  logic [RadW-1:0]    r_r;
  logic signed [15:0] sum_x, sum_y;
  logic               degen;

  // pipeline control
  logic [NStg:1] stg_vld_r;
  logic [NStg:1] stg_en;

  // stage payloads
  coord_t             px_r, py_r;
  logic [OffW-1:0]    dx0_r, dxm_r, dxp_r, dy0_r, dym_r, dyp_r;
  logic [SqW-1:0]     sx0_r, sxm_r, sxp_r, sy0_r, sym_r, syp_r;
  logic [ProdW-1:0]   tx0_r, txm_r, txp_r, ty0_r, tym_r, typ_r;
  logic [MeasW-1:0]   e_r, a0y_r, a1y_r, a0x_r, a1x_r;
  logic               le_r, ylt0_r, ylt1_r, ygt0_r, ygt1_r;
  logic               xlt0_r, xlt1_r, xgt0_r, xgt1_r;
  logic               hit_r, hit_nxt;

  logic signed [17:0] ox, oy;
  logic [MeasW-1:0]   r_ext;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r     <= '0;
      ay_r     <= '0;
      bx_r     <= '0;
      by_r     <= '0;
      filled_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CORNER_A_X: ax_r     <= cfg_data[CoordW-1:0];
        REG_CORNER_A_Y: ay_r     <= cfg_data[CoordW-1:0];
        REG_CORNER_B_X: bx_r     <= cfg_data[CoordW-1:0];
        REG_CORNER_B_Y: by_r     <= cfg_data[CoordW-1:0];
        REG_FILLED:     filled_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // derived terms settle well before an item reaches the stage that uses them
  always_ff @(posedge clk) begin
    w_r  <= abs_side(16'(ax_r) - 16'(bx_r));
    h_r  <= abs_side(16'(ay_r) - 16'(by_r));
    w2_r <= Side2W'(w_r * w_r);
    h2_r <= Side2W'(h_r * h_r);
    r_r  <= RadW'(w2_r * h2_r);
  end

  assign sum_x = 16'(ax_r) + 16'(bx_r);
  assign sum_y = 16'(ay_r) + 16'(by_r);
  assign degen = (w_r == '0) || (h_r == '0);
  assign r_ext = MeasW'(r_r);

  // a stage moves when it is empty or its successor moves
  always_comb begin
    stg_en[NStg] = !stg_vld_r[NStg] || out_tready;
    for (int k = NStg - 1; k >= 1; k--) begin
      stg_en[k] = !stg_vld_r[k] || stg_en[k+1];
    end
  end

  assign in_tready = stg_en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= '0;
    end else begin
      if (stg_en[1]) stg_vld_r[1] <= in_tvalid;
      for (int k = 2; k <= NStg; k++) begin
        if (stg_en[k]) stg_vld_r[k] <= stg_vld_r[k-1];
      end
    end
  end

  // stage 1: capture point
  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      px_r <= in_tdata[CoordW-1:0];
      py_r <= in_tdata[2*CoordW-1:CoordW];
    end
  end

  // stage 2: doubled offsets from the center, with probes
  assign ox = {{2{px_r[CoordW-1]}}, px_r, 1'b0} - {{2{sum_x[15]}}, sum_x};
  assign oy = {{2{py_r[CoordW-1]}}, py_r, 1'b0} - {{2{sum_y[15]}}, sum_y};

  always_ff @(posedge clk) begin
    if (stg_en[2]) begin
      dx0_r <= abs_off(ox);
      dxm_r <= abs_off(ox - ProbeOff2);
      dxp_r <= abs_off(ox + ProbeOff2);
      dy0_r <= abs_off(oy);
      dym_r <= abs_off(oy - ProbeOff2);
      dyp_r <= abs_off(oy + ProbeOff2);
    end
  end

  // stage 3: squares
  always_ff @(posedge clk) begin
    if (stg_en[3]) begin
      sx0_r <= square_off(dx0_r);
      sxm_r <= square_off(dxm_r);
      sxp_r <= square_off(dxp_r);
      sy0_r <= square_off(dy0_r);
      sym_r <= square_off(dym_r);
      syp_r <= square_off(dyp_r);
    end
  end

  // stage 4: x terms weighted by h^2, y terms by w^2
  always_ff @(posedge clk) begin
    if (stg_en[4]) begin
      tx0_r <= scale_sq(sx0_r, h2_r);
      txm_r <= scale_sq(sxm_r, h2_r);
      txp_r <= scale_sq(sxp_r, h2_r);
      ty0_r <= scale_sq(sy0_r, w2_r);
      tym_r <= scale_sq(sym_r, w2_r);
      typ_r <= scale_sq(syp_r, w2_r);
    end
  end

  // stage 5: measures at the point and the four probes
  always_ff @(posedge clk) begin
    if (stg_en[5]) begin
      e_r   <= {1'b0, tx0_r} + {1'b0, ty0_r};
      a0y_r <= {1'b0, tx0_r} + {1'b0, tym_r};
      a1y_r <= {1'b0, tx0_r} + {1'b0, typ_r};
      a0x_r <= {1'b0, txm_r} + {1'b0, ty0_r};
      a1x_r <= {1'b0, txp_r} + {1'b0, ty0_r};
    end
  end

  // stage 6: compare against the radius term
  always_ff @(posedge clk) begin
    if (stg_en[6]) begin
      le_r   <= e_r <= r_ext;
      ylt0_r <= a0y_r < r_ext;
      ylt1_r <= r_ext < a1y_r;
      ygt0_r <= a0y_r > r_ext;
      ygt1_r <= r_ext > a1y_r;
      xlt0_r <= a0x_r < r_ext;
      xlt1_r <= r_ext < a1x_r;
      xgt0_r <= a0x_r > r_ext;
      xgt1_r <= r_ext > a1x_r;
    end
  end

  // stage 7: output register
  always_comb begin
    if (degen) begin
      hit_nxt = 1'b0;
    end else if (filled_r) begin
      hit_nxt = le_r;
    end else begin
      hit_nxt = between(ylt0_r, ylt1_r, ygt0_r, ygt1_r) ||
                between(xlt0_r, xlt1_r, xgt0_r, xgt1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[NStg]) hit_r <= hit_nxt;
  end

  assign out_tvalid = stg_vld_r[NStg];
  assign out_tdata  = {{(OutDataW-1){1'b0}}, hit_r};

  // assertions
  a_accept_fills_stage1 : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> stg_vld_r[1])
    else $error("accepted request did not enter the pipeline");

  a_stage6_reaches_out : assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_r[NStg-1] && stg_en[NStg-1] |=> out_tvalid)
    else $error("compare stage result lost before output");

  a_no_hit_degenerate : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !degen)
    else $error("hit reported for a degenerate box");

  a_ready_when_room : assert property (@(posedge clk) disable iff (!rst_n)
    !stg_vld_r[1] |-> in_tready)
    else $error("input stalled with an empty first stage");

endmodule
